// ===== design/csa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the contiguous sector allocator.
// No dependencies; imported by every module of the block.

package csa_pkg;

  // Map word geometry: one 64-bit word per memory row.
  localparam int W     = 64;
  localparam int LOG_W = 6;

  localparam int TOTAL_W = 13;
  localparam int START_W = 7;

  // Configuration register indexes (byte address 4*index).
  localparam logic REG_TOTAL_SECTORS = 1'b0;
  localparam logic REG_DATA_START    = 1'b1;

  typedef enum logic [1:0] {
    OP_FORMAT  = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FMT,
    S_SCAN,
    S_UPD_RD,
    S_UPD_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  needed_count;
    logic [11:0] old_first;
    logic [3:0]  old_count;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [11:0] first_sector;
  } out_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total_sectors;
    logic [START_W-1:0] data_start;
  } cfg_t;

  typedef struct packed {
    logic done;
    out_t result;
  } eng_sts_t;

endpackage

// ===== design/csa_map.sv =====
`timescale 1ns / 1ps
// Allocation map storage: one write port, one read port, registered read data.
// Depends on csa_pkg for the word width.

module csa_map
  import csa_pkg::*;
#(
  parameter int NUM_WORDS = 64,
  parameter int WW        = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [WW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [WW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/csa_match.sv =====
`timescale 1ns / 1ps
// Run detector for one map word: finds the lowest bit that ends a free run
// of the requested length, looking back into the previous word. Uses csa_pkg.

module csa_match
  import csa_pkg::*;
#(
  parameter int MAX_RUN = 8
) (
  input  logic [2*W-1:0]     ext_free,   // {current word, previous word}
  input  logic [MAX_RUN-1:0] need_mask,  // top needed_count bits set
  output logic               hit,
  output logic [LOG_W-1:0]   pos
);

  logic [W-1:0] ok;

  always_comb begin
    logic [MAX_RUN-1:0] win;
    win = '0;
    for (int j = 0; j < W; j++) begin
      // bit MAX_RUN-1 of the window is position j of the current word
      win   = ext_free[W + j - MAX_RUN + 1 +: MAX_RUN];
      ok[j] = &(win | ~need_mask);
    end
  end

  always_comb begin
    hit = |ok;
    pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (ok[j]) begin
        pos = LOG_W'(j);
      end
    end
  end

endmodule

// ===== design/csa_engine.sv =====
`timescale 1ns / 1ps
// Allocator sequencer: clearing pass, format sweep, first-fit scan and
// read-modify-write map updates. Uses csa_pkg, csa_map and csa_match.

module csa_engine
  import csa_pkg::*;
#(
  parameter int MAP_BITS = 4096,
  parameter int MAX_RUN  = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_t      req,
  input  cfg_t     cfg,
  input  logic     take,
  output logic     ready,
  output eng_sts_t sts
);

  localparam int NUM_WORDS = (MAP_BITS + W - 1) / W;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW        = $clog2(MAP_BITS);
  localparam int PW        = ((SW > TOTAL_W) ? SW : TOTAL_W) + 1;
  localparam int UW        = PW - LOG_W;

  state_t state, state_next;

  logic [WW:0]        idx;
  logic               proc_valid;
  logic [WW-1:0]      proc_idx;
  logic [1:0]         upd_k;
  in_t                req_q;
  logic [PW-1:0]      cand;
  logic [3:0]         set_cnt;
  out_t               res;
  logic [W-1:0]       prev_free;

  logic               rd_en, wr_en;
  logic [WW-1:0]      rd_addr, wr_addr;
  logic [W-1:0]       rd_data, wr_data;

  logic               start_fail;
  logic               sweep_last, scan_last;
  logic [PW-1:0]      ds, total, limit;
  logic [PW-1:0]      old_lo, old_hi, set_lo, set_hi;
  logic [PW-1:0]      base_s, base_f, base_u, upd_sector, cand_calc;
  logic [UW-1:0]      upd_word;
  logic               upd_in_map;
  logic [W-1:0]       free_cur, fmt_word, upd_word_data;
  logic [MAX_RUN-1:0] need_mask;
  logic               hit;
  logic [LOG_W-1:0]   pos;

  // Bits of the word at base whose sector is at or above x.
  function automatic logic [W-1:0] ge_mask(input logic [PW-1:0] base,
                                           input logic [PW-1:0] x);
    logic [PW-1:0] d;
    d = x - base;
    if (x <= base) begin
      return '1;
    end else if (d >= PW'(W)) begin
      return '0;
    end else begin
      return {W{1'b1}} << d[LOG_W-1:0];
    end
  endfunction

  function automatic logic [W-1:0] range_mask(input logic [PW-1:0] base,
                                              input logic [PW-1:0] lo,
                                              input logic [PW-1:0] hi);
    return ge_mask(base, lo) & ~ge_mask(base, hi);
  endfunction

  csa_map #(
    .NUM_WORDS (NUM_WORDS),
    .WW        (WW)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  csa_match #(
    .MAX_RUN (MAX_RUN)
  ) u_match (
    .ext_free  ({free_cur, prev_free}),
    .need_mask (need_mask),
    .hit       (hit),
    .pos       (pos)
  );

  assign ds     = PW'(cfg.data_start);
  assign total  = PW'(cfg.total_sectors);
  assign limit  = (total < PW'(MAP_BITS)) ? total : PW'(MAP_BITS);
  assign old_lo = PW'(req_q.old_first);
  assign old_hi = old_lo + PW'(req_q.old_count);
  assign set_lo = cand;
  assign set_hi = cand + PW'(set_cnt);

  assign start_fail = (req.operation == OP_ALLOC) ? (int'(req.needed_count) > MAX_RUN)
                    : !(req.operation == OP_FORMAT || req.operation == OP_RELEASE);

  assign sweep_last = (idx[WW-1:0] == WW'(NUM_WORDS - 1));
  assign scan_last  = (proc_idx == WW'(NUM_WORDS - 1));

  // scan datapath: word arriving from the map belongs to proc_idx
  assign base_s    = PW'({proc_idx, LOG_W'(0)});
  assign free_cur  = (~rd_data | range_mask(base_s, old_lo, old_hi))
                     & ge_mask(base_s, ds) & ~ge_mask(base_s, limit);
  assign need_mask = ~({MAX_RUN{1'b1}} >> req_q.needed_count);
  assign cand_calc = base_s + PW'(pos) + PW'(1) - PW'(req_q.needed_count);

  // format sweep
  assign base_f   = PW'({idx[WW-1:0], LOG_W'(0)});
  assign fmt_word = ~ge_mask(base_f, ds) | ge_mask(base_f, total);

  // update: old range words, then new run words; repeats are idempotent
  always_comb begin
    case (upd_k)
      2'd0:    upd_sector = old_lo;
      2'd1:    upd_sector = old_lo + PW'(W);
      2'd2:    upd_sector = cand;
      default: upd_sector = cand + PW'(W);
    endcase
  end
  assign upd_word      = upd_sector[PW-1:LOG_W];
  assign upd_in_map    = (upd_word < UW'(NUM_WORDS));
  assign base_u        = {upd_word, LOG_W'(0)};
  assign upd_word_data = (rd_data & ~range_mask(base_u, old_lo, old_hi))
                         | range_mask(base_u, set_lo, set_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx[WW-1:0];
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (start_fail) begin
            state_next = S_DONE;
          end else begin
            unique case (req.operation)
              OP_FORMAT:  state_next = S_FMT;
              OP_ALLOC:   state_next = (req.needed_count == 4'd0) ? S_UPD_RD : S_SCAN;
              default:    state_next = S_UPD_RD;
            endcase
          end
        end
      end
      S_FMT: begin
        wr_en   = 1'b1;
        wr_addr = idx[WW-1:0];
        wr_data = fmt_word;
        if (sweep_last) state_next = S_DONE;
      end
      S_SCAN: begin
        rd_en   = (idx < (WW + 1)'(NUM_WORDS));
        rd_addr = idx[WW-1:0];
        if (proc_valid && hit) begin
          state_next = S_UPD_RD;
        end else if (proc_valid && scan_last) begin
          state_next = S_DONE;
        end
      end
      S_UPD_RD: begin
        if (upd_in_map) begin
          rd_en      = 1'b1;
          rd_addr    = upd_word[WW-1:0];
          state_next = S_UPD_WR;
        end else if (upd_k == 2'd3) begin
          state_next = S_DONE;
        end
      end
      S_UPD_WR: begin
        wr_en      = 1'b1;
        wr_addr    = upd_word[WW-1:0];
        wr_data    = upd_word_data;
        state_next = (upd_k == 2'd3) ? S_DONE : S_UPD_RD;
      end
      S_DONE: begin
        if (take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      proc_valid <= 1'b0;
      upd_k      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx        <= '0;
          proc_valid <= 1'b0;
          upd_k      <= '0;
        end
        S_CLEAR, S_FMT: idx <= idx + 1'b1;
        S_SCAN: begin
          proc_valid <= rd_en;
          if (rd_en) idx <= idx + 1'b1;
        end
        S_UPD_RD: begin
          if (!upd_in_map && upd_k != 2'd3) upd_k <= upd_k + 1'b1;
        end
        S_UPD_WR: upd_k <= upd_k + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst == 1'b0) begin
      if (state == S_SCAN && rd_en) proc_idx <= idx[WW-1:0];
      if (state == S_IDLE && start) begin
        req_q     <= req;
        cand      <= '0;
        set_cnt   <= '0;
        prev_free <= '0;
        res       <= '{status: start_fail, first_sector: '0};
      end else if (state == S_SCAN && proc_valid) begin
        prev_free <= free_cur;
        if (hit) begin
          cand             <= cand_calc;
          set_cnt          <= req_q.needed_count;
          res.first_sector <= cand_calc[11:0];
        end else if (scan_last) begin
          res.status <= 1'b1;
        end
      end
    end
  end

  assign ready      = (state == S_IDLE);
  assign sts.done   = (state == S_DONE);
  assign sts.result = res;

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_FMT || state == S_UPD_WR))
    else $error("map written outside a sweep or update");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD_WR) |-> ($past(state) == S_UPD_RD && $past(rd_en)))
    else $error("update write without a preceding read");

  a_hit_needs_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && proc_valid && hit) |-> (req_q.needed_count != 4'd0))
    else $error("scan hit with an empty request");

  a_first_only_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res.first_sector != 12'd0)
      |-> (req_q.operation == OP_ALLOC && !res.status))
    else $error("nonzero first sector outside a good allocate");

endmodule

// ===== design/contiguous_sector_allocator.sv =====
`timescale 1ns / 1ps
// Contiguous sector allocator: a one-bit-per-sector map kept in a 64-bit-wide
// memory with one read and one write port, MAP_BITS/64 rows. After reset the
// block runs a clearing pass over every row and holds req_stall high during
// it; configuration writes are taken anytime. Items are handled one at a
// time. Format sweeps every row. Allocate scans one map row per cycle from
// row 0 until the first fitting run, then rewrites up to four rows, each
// read and then written back; release and an empty allocate go straight
// to these rewrites. The scan length, set by the single map read port,
// dominates. A result is held in an output register so a new request can
// start while it waits.
// MAX_RUN must not exceed 64.

module contiguous_sector_allocator
  import csa_pkg::*;
#(
  parameter int MAP_BITS = 4096,
  parameter int MAX_RUN  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  in_t         req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output out_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  eng_sts_t sts;
  logic     ready, start, take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_sectors <= TOTAL_W'(4096);
      cfg.data_start    <= START_W'(3);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TOTAL_SECTORS: cfg.total_sectors <= pwdata[TOTAL_W-1:0];
        REG_DATA_START:    cfg.data_start    <= pwdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_SECTORS: prdata = 32'(cfg.total_sectors);
      REG_DATA_START:    prdata = 32'(cfg.data_start);
      default:           prdata = '0;
    endcase
  end

  assign req_stall = !ready;
  assign start     = req_valid && ready;
  // output register frees when empty or when its beat is taken
  assign take      = sts.done && (!rsp_valid || !rsp_stall);

  csa_engine #(
    .MAP_BITS (MAP_BITS),
    .MAX_RUN  (MAX_RUN)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .cfg   (cfg),
    .take  (take),
    .ready (ready),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rsp <= sts.result;
  end

endmodule
